@@ hw/rtl/s2i_pkg.sv @@
// Shared types and constants for the string-to-integer parser.
package s2i_pkg;

   // Field widths
   localparam int unsigned CharWidth   = 8;
   localparam int unsigned BaseWidth   = 6;
   localparam int unsigned ValueWidth  = 32;
   localparam int unsigned OffsetWidth = 16;

   // Default saturation limit of the consumed byte count
   localparam int unsigned DefaultMaxLength = 65535;

   // Radix codes
   localparam logic [BaseWidth-1:0] BaseAuto  = 6'd0;
   localparam logic [BaseWidth-1:0] BaseOct   = 6'd8;
   localparam logic [BaseWidth-1:0] BaseDec   = 6'd10;
   localparam logic [BaseWidth-1:0] BaseHex   = 6'd16;
   localparam logic [BaseWidth-1:0] BaseReset = BaseDec;

   // Character codes
   localparam logic [CharWidth-1:0] CharNul    = 8'h00;
   localparam logic [CharWidth-1:0] CharSpace  = 8'h20;
   localparam logic [CharWidth-1:0] CharPlus   = 8'h2B;
   localparam logic [CharWidth-1:0] CharMinus  = 8'h2D;
   localparam logic [CharWidth-1:0] CharZero   = 8'h30;
   localparam logic [CharWidth-1:0] CharNine   = 8'h39;
   localparam logic [CharWidth-1:0] CharUpperA = 8'h41;
   localparam logic [CharWidth-1:0] CharLowerA = 8'h61;
   localparam logic [CharWidth-1:0] CharUpperX = 8'h58;
   localparam logic [CharWidth-1:0] CharLowerX = 8'h78;

   // Lower to upper case distance, and value of the first letter digit
   localparam logic [CharWidth-1:0] CaseFold   = CharLowerA - CharUpperA;
   localparam logic [CharWidth-1:0] LetterBase = 8'd10;

   // Result of one byte step, handed from the step logic to the output register
   typedef struct packed {
      logic                   emit;
      logic [ValueWidth-1:0]  value;
      logic [OffsetWidth-1:0] offset;
   } s2i_result_type;

endpackage

@@ hw/rtl/s2i_step.sv @@
// Per-string parse state and the one-byte step: prefix, sign, radix and digit accumulation.
module s2i_step import s2i_pkg::*; #(
   parameter int unsigned MAX_LENGTH = DefaultMaxLength
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_fire,
   input  logic [CharWidth-1:0] step_char,
   input  logic                 step_start,
   input  logic [BaseWidth-1:0] cfg_base,
   output s2i_result_type       step_result
);

   localparam int unsigned CountWidth = $clog2(MAX_LENGTH + 1);
   localparam int unsigned ExtWidth   = (CountWidth > OffsetWidth) ? CountWidth : OffsetWidth;
   localparam logic [CountWidth-1:0]  CountMax  = CountWidth'(MAX_LENGTH);
   localparam logic [OffsetWidth-1:0] OffsetMax = '1;

   typedef enum logic [2:0] {
      PH_DONE,
      PH_SPACE,
      PH_PREFIX,
      PH_ZERO_AUTO,
      PH_ZERO_HEX,
      PH_DIGITS
   } phase_type;

   typedef struct packed {
      logic                 is_digit;
      logic [CharWidth-1:0] digit;
   } digit_type;

   // Fold case and map a byte to its digit value; letters count from ten
   function automatic digit_type decode_digit(input logic [CharWidth-1:0] ch);
      logic [CharWidth-1:0] v;
      digit_type            d;
      v = ch;
      if (v >= CharLowerA) begin
         v = v - CaseFold;
      end
      if (v >= CharUpperA) begin
         d.is_digit = 1'b1;
         d.digit    = v - CharUpperA + LetterBase;
      end else if (v >= CharZero && v <= CharNine) begin
         d.is_digit = 1'b1;
         d.digit    = v - CharZero;
      end else begin
         d.is_digit = 1'b0;
         d.digit    = v;
      end
      return d;
   endfunction

   phase_type               phase_ff, phase_in, cur_phase;
   logic                    neg_ff, neg_in, cur_neg;
   logic [BaseWidth-1:0]    base_ff, base_in, cur_base, prefix_base;
   logic [ValueWidth-1:0]   acc_ff, acc_in, cur_acc, mac;
   logic [CountWidth-1:0]   count_ff, count_in, cur_count;
   logic [ExtWidth-1:0]     count_ext;
   logic                    count_up, emit, do_prefix, try_digit;
   digit_type               dec;

   // A start byte sees cleared per-string state
   assign cur_phase = step_start ? PH_SPACE : phase_ff;
   assign cur_neg   = step_start ? 1'b0 : neg_ff;
   assign cur_base  = step_start ? BaseAuto : base_ff;
   assign cur_acc   = step_start ? '0 : acc_ff;
   assign cur_count = step_start ? '0 : count_ff;

   assign prefix_base = (cfg_base == BaseAuto) ? BaseDec : cfg_base;
   assign dec         = decode_digit(step_char);
   assign mac         = cur_acc * ValueWidth'(base_in) + ValueWidth'(dec.digit);

   // Next state for one byte
   always_comb begin
      phase_in  = cur_phase;
      neg_in    = cur_neg;
      base_in   = cur_base;
      acc_in    = cur_acc;
      count_up  = 1'b0;
      emit      = 1'b0;
      do_prefix = 1'b0;
      try_digit = 1'b0;

      case (cur_phase)
         PH_SPACE: begin
            if (step_char == CharNul) begin
               emit     = 1'b1;
               phase_in = PH_DONE;
            end else if (step_char <= CharSpace) begin
               count_up = 1'b1;
            end else if (step_char inside {CharPlus, CharMinus}) begin
               neg_in   = (step_char == CharMinus);
               count_up = 1'b1;
               phase_in = PH_PREFIX;
            end else begin
               do_prefix = 1'b1;
            end
         end
         PH_PREFIX: begin
            do_prefix = 1'b1;
         end
         PH_ZERO_AUTO, PH_ZERO_HEX: begin
            phase_in = PH_DIGITS;
            if (step_char inside {CharLowerX, CharUpperX}) begin
               base_in  = BaseHex;
               count_up = 1'b1;
            end else begin
               base_in   = (cur_phase == PH_ZERO_AUTO) ? BaseOct : BaseHex;
               try_digit = 1'b1;
            end
         end
         PH_DIGITS: begin
            try_digit = 1'b1;
         end
         default: begin
         end
      endcase

      // Radix settles here; a leading zero may still turn into a 0x prefix
      if (do_prefix) begin
         if (step_char == CharZero && cfg_base == BaseAuto) begin
            count_up = 1'b1;
            phase_in = PH_ZERO_AUTO;
         end else if (step_char == CharZero && cfg_base == BaseHex) begin
            count_up = 1'b1;
            phase_in = PH_ZERO_HEX;
         end else begin
            base_in   = prefix_base;
            phase_in  = PH_DIGITS;
            try_digit = 1'b1;
         end
      end

      // Accumulate a digit below the radix, otherwise stop
      if (try_digit) begin
         if (dec.is_digit && dec.digit < CharWidth'(base_in)) begin
            acc_in   = mac;
            count_up = 1'b1;
         end else begin
            emit     = 1'b1;
            phase_in = PH_DONE;
         end
      end
   end

   // Saturating byte count
   assign count_in = (count_up && cur_count < CountMax) ? cur_count + 1'b1 : cur_count;

   // Result from the state before this byte
   assign count_ext          = ExtWidth'(cur_count);
   assign step_result.emit   = emit;
   assign step_result.value  = cur_neg ? (ValueWidth'(0) - cur_acc) : cur_acc;
   assign step_result.offset = (count_ext > ExtWidth'(OffsetMax)) ? OffsetMax
                                                                  : count_ext[OffsetWidth-1:0];

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DONE;
         neg_ff   <= 1'b0;
         base_ff  <= BaseAuto;
         acc_ff   <= '0;
         count_ff <= '0;
      end else if (step_fire) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         base_ff  <= base_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   // Once done, only a start byte can produce a result
   assert property (@(posedge clock) disable iff (reset)
      step_fire && !step_start && phase_ff == PH_DONE |-> !step_result.emit)
      else $error("result from a finished string");

   // Every result closes the string
   assert property (@(posedge clock) disable iff (reset)
      step_fire && step_result.emit |=> phase_ff == PH_DONE)
      else $error("parse continued after a result");

   // Digit phase always holds a usable radix
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DIGITS |-> base_ff != BaseAuto)
      else $error("digit phase without radix");

   // Byte count stays within its limit
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountMax)
      else $error("byte count above limit");
`endif

endmodule

@@ hw/rtl/string_to_integer_parser.sv @@
// Top level: input word register, radix register, step logic and result register.
// Throughput: one byte per cycle while no stalled result holds it; the digit step is a 32 x 6 bit multiply-add.
// Path: the stopping byte is held in the input register, then its result is written to the
//   result register, which presents the result word until it is taken.
// Reset (synchronous, active high): parse state done, radix register 10, both registers empty.
// A stalled result blocks only a byte that would produce another result.
module string_to_integer_parser import s2i_pkg::*; #(
   parameter int unsigned MAX_LENGTH = DefaultMaxLength
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [CharWidth-1:0]          req_char_code,
   input  logic                          req_start_of_string,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [ValueWidth-1:0]  rsp_result_value,
   output logic [OffsetWidth-1:0]        rsp_end_offset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [BaseWidth-1:0]          csr_numeric_base
);

   logic                   in_valid_ff, in_valid_in;
   logic [CharWidth-1:0]   in_char_ff, in_char_in;
   logic                   in_start_ff, in_start_in;
   logic [BaseWidth-1:0]   base_ff, base_in;
   logic                   out_valid_ff, out_valid_in;
   logic [ValueWidth-1:0]  out_value_ff, out_value_in;
   logic [OffsetWidth-1:0] out_offset_ff, out_offset_in;
   logic                   req_take, out_free, step_fire, out_load;
   s2i_result_type         step_result;

   // Handshake control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step_fire = in_valid_ff && (out_free || !step_result.emit);
   assign out_load  = step_fire && step_result.emit;
   assign req_stall = in_valid_ff && !step_fire;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Input word register
   assign in_valid_in = req_take ? 1'b1 : (step_fire ? 1'b0 : in_valid_ff);
   assign in_char_in  = req_take ? req_char_code : in_char_ff;
   assign in_start_in = req_take ? req_start_of_string : in_start_ff;

   // Radix register
   assign base_in = (csr_valid && csr_ready) ? csr_numeric_base : base_ff;

   // Result register
   assign out_valid_in  = out_load ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
   assign out_value_in  = out_load ? step_result.value : out_value_ff;
   assign out_offset_in = out_load ? step_result.offset : out_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         base_ff      <= BaseReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         base_ff      <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff    <= in_char_in;
      in_start_ff   <= in_start_in;
      out_value_ff  <= out_value_in;
      out_offset_ff <= out_offset_in;
   end

   s2i_step #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_step (
      .clock       (clock),
      .reset       (reset),
      .step_fire   (step_fire),
      .step_char   (in_char_ff),
      .step_start  (in_start_ff),
      .cfg_base    (base_ff),
      .step_result (step_result)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_value = signed'(out_value_ff);
   assign rsp_end_offset   = out_offset_ff;

endmodule
